// File: rtl/pds_pkg.sv
`default_nettype none
package pds_pkg;

  localparam int TARGET_W    = 18;
  localparam int REF_W       = 20;
  localparam int RANGE_W     = 4;
  localparam int RDW_W       = 7;
  localparam int VDW_W       = 9;
  localparam int FREQ_W      = 18;
  localparam int BYTE_W      = 8;

  localparam int RDW_LIMIT_DEF = 128;
  localparam int VDW_COUNT_DEF = 512;

  // shared divider: 2*ref over an 8-bit divisor
  localparam int DIV_W  = REF_W + 1;
  localparam int DVS_W  = 8;
  localparam int DIV_CW = $clog2(DIV_W + 1);

  // VCO quotient: 2*ref*(vdw+8)/2 at most
  localparam int VCO_W = 30;

  localparam logic [DVS_W-1:0] LIM_DIV   = DVS_W'(200);
  localparam logic [VCO_W-1:0] VCO_MIN   = VCO_W'(12000);
  localparam logic [VCO_W-1:0] VCO_MAX   = VCO_W'(240000);
  localparam logic [FREQ_W-1:0] ERR_MAX  = FREQ_W'(100);
  localparam logic [RANGE_W-1:0] RANGE_MAX = RANGE_W'(7);
  localparam int PRIME_STEPS = 8;

  // frequency = (vco * recip) >> RECIP_SHIFT, exact for 18-bit vco
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 22;
  localparam int PROD_W      = FREQ_W + RECIP_W;

  typedef struct packed {
    logic [TARGET_W-1:0] target_freq;
    logic [REF_W-1:0]    ref_freq;
    logic [RANGE_W-1:0]  range_code;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [RDW_W-1:0]  best_rdw;
    logic [VDW_W-1:0]  best_vdw;
    logic [FREQ_W-1:0] achieved_freq;
    logic [BYTE_W-1:0] rdw_reg_byte;
    logic [BYTE_W-1:0] vdw_reg_byte;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIM_GO,
    S_LIM_WAIT,
    S_RD_GO,
    S_RD_WAIT,
    S_PRIME,
    S_MUL,
    S_CMP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic idle;
    logic div_start;
    logic div_lim;
    logic take_limit;
    logic take_ab;
    logic prime;
    logic mul;
    logic cmp;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic range_bad;
    logic div_done;
    logic limit_zero;
    logic prime_last;
    logic vdw_last;
    logic rdw_last;
    logic out_free;
  } stat_t;

  // ceil(2^21 / od) for od = {6,2,8,4,5,7,1,3}[range]
  function automatic logic [RECIP_W-1:0] od_recip(input logic [2:0] range);
    logic [RECIP_W-1:0] r;
    case (range)
      3'd0:    r = RECIP_W'(349526);
      3'd1:    r = RECIP_W'(1048576);
      3'd2:    r = RECIP_W'(262144);
      3'd3:    r = RECIP_W'(524288);
      3'd4:    r = RECIP_W'(419431);
      3'd5:    r = RECIP_W'(299594);
      3'd6:    r = RECIP_W'(2097152);
      3'd7:    r = RECIP_W'(699051);
      default: r = RECIP_W'(2097152);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pds_div.sv
`default_nettype none
module pds_div
  import pds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quot,
  output logic [DVS_W-1:0]      rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  // one restoring step per cycle, MSB first
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: rtl/pds_ctrl.sv
`default_nettype none
module pds_ctrl
  import pds_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) state_nxt = stat.range_bad ? S_FIN : S_LIM_GO;
      end
      S_LIM_GO:   state_nxt = S_LIM_WAIT;
      S_LIM_WAIT: begin
        if (stat.div_done) state_nxt = stat.limit_zero ? S_FIN : S_RD_GO;
      end
      S_RD_GO:    state_nxt = S_RD_WAIT;
      S_RD_WAIT: begin
        if (stat.div_done) state_nxt = S_PRIME;
      end
      S_PRIME: begin
        if (stat.prime_last) state_nxt = S_MUL;
      end
      S_MUL:      state_nxt = S_CMP;
      S_CMP: begin
        if (!stat.vdw_last)     state_nxt = S_MUL;
        else if (stat.rdw_last) state_nxt = S_FIN;
        else                    state_nxt = S_RD_GO;
      end
      S_FIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl            = '0;
    ctrl.idle       = state_r == S_IDLE;
    ctrl.div_start  = (state_r == S_LIM_GO) || (state_r == S_RD_GO);
    ctrl.div_lim    = state_r == S_LIM_GO;
    ctrl.take_limit = (state_r == S_LIM_WAIT) && stat.div_done;
    ctrl.take_ab    = (state_r == S_RD_WAIT) && stat.div_done;
    ctrl.prime      = state_r == S_PRIME;
    ctrl.mul        = state_r == S_MUL;
    ctrl.cmp        = state_r == S_CMP;
    ctrl.finish     = (state_r == S_FIN) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/pll_divider_search_top.sv
`default_nettype none
// Divider search for a clock synthesizer.
// A request on in_* carries a target frequency, a reference frequency and a
// range code; one result on out_* returns the best reference and VCO divider
// words, the frequency they reach, the ok flag and the two packed register
// bytes. in_ready is high only while the search engine is idle, so one
// request is worked on at a time.
// A bad range code goes straight to the output register. Otherwise the
// engine finds the rdw bound (ref/200 on the shared divider), then for
// each rdw value divides 2*ref by rdw+2, takes 8 priming steps and sweeps
// the VDW_COUNT vdw values (multiply, then compare, for each), and at the
// end loads the output register. One request is searched at a time; the
// engine goes back to idle before it takes the next. The shared bit-serial
// divider and the multiply and compare of each pair set the search time.
// The result sits in an output register; a new request may be taken while
// it waits, but the next result holds the engine until out_ready drains it.
// Reset (rst_n low, synchronous) idles the engine and drops any result.
module pll_divider_search_top
  import pds_pkg::*;
#(
  parameter int RDW_LIMIT = RDW_LIMIT_DEF,
  parameter int VDW_COUNT = VDW_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int RCW = $clog2(RDW_LIMIT + 1);

  ctrl_t ctrl;
  stat_t stat;

  // request fields
  logic [TARGET_W-1:0] target_r;
  logic [REF_W-1:0]    ref_r;
  logic [2:0]          range_r;
  logic                bad_r;

  // search counters
  logic [RCW-1:0]      limit_r;
  logic [RCW-1:0]      rdw_r;
  logic [VDW_W-1:0]    vdw_r;
  logic [2:0]          prime_cnt_r;

  // 2*ref = d*a + b for the current rdw
  logic [DIV_W-1:0]    a_r;
  logic [DVS_W-1:0]    b_r;

  // running VCO quotient and remainder
  logic [VCO_W-1:0]    vq_r;
  logic [DVS_W-1:0]    vr_r;

  logic [FREQ_W-1:0]   f_r;
  logic                inr_r;

  logic [FREQ_W-1:0]   best_err_r;
  logic [RDW_W-1:0]    best_rdw_r;
  logic [VDW_W-1:0]    best_vdw_r;
  logic [FREQ_W-1:0]   best_f_r;

  out_t                out_r;
  logic                out_valid_r;

  // divider hookup
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;
  logic [DVS_W-1:0]    div_rem;
  logic [DIV_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic [DVS_W-1:0]    dsr;

  logic                accept;
  logic [RCW-1:0]      limit_nxt;
  logic [DIV_W-1:0]    qm2;
  logic [DVS_W:0]      vsum;
  logic                vwrap;
  logic [VCO_W-1:0]    vq_step;
  logic [DVS_W-1:0]    vr_step;
  logic [PROD_W-1:0]   prod;
  logic [FREQ_W-1:0]   err;
  logic                better;
  logic                ok;
  out_t                res;

  assign accept   = in_valid && ctrl.idle;
  assign in_ready = ctrl.idle;

  assign dsr          = DVS_W'(rdw_r) + DVS_W'(2);
  assign div_dividend = ctrl.div_lim ? {1'b0, ref_r} : {ref_r, 1'b0};
  assign div_divisor  = ctrl.div_lim ? LIM_DIV : dsr;

  pds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // rdw bound: ref/200 below 2 takes the full limit, else min(q-2, limit)
  assign qm2 = div_quot - DIV_W'(2);
  always_comb begin
    if (div_quot < DIV_W'(2))            limit_nxt = RCW'(RDW_LIMIT);
    else if (qm2 > DIV_W'(RDW_LIMIT))    limit_nxt = RCW'(RDW_LIMIT);
    else                                 limit_nxt = qm2[RCW-1:0];
  end

  // advance the numerator by 2*ref: quotient gains a (plus one on carry)
  assign vsum    = {1'b0, vr_r} + {1'b0, b_r};
  assign vwrap   = vsum >= {1'b0, dsr};
  assign vr_step = vwrap ? DVS_W'(vsum - {1'b0, dsr}) : vsum[DVS_W-1:0];
  assign vq_step = vq_r + VCO_W'(a_r) + VCO_W'(vwrap);

  assign prod = vq_r[FREQ_W-1:0] * od_recip(range_r);

  assign err    = (f_r > target_r) ? (f_r - target_r) : (target_r - f_r);
  assign better = inr_r && (err < best_err_r);

  assign stat.in_valid   = in_valid;
  assign stat.range_bad  = in_data.range_code > RANGE_MAX;
  assign stat.div_done   = div_done;
  assign stat.limit_zero = limit_nxt == '0;
  assign stat.prime_last = prime_cnt_r == 3'(PRIME_STEPS - 1);
  assign stat.vdw_last   = vdw_r == VDW_W'(VDW_COUNT - 1);
  assign stat.rdw_last   = RCW'(rdw_r + 1'b1) == limit_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  pds_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      target_r   <= in_data.target_freq;
      ref_r      <= in_data.ref_freq;
      range_r    <= in_data.range_code[2:0];
      bad_r      <= in_data.range_code > RANGE_MAX;
      best_err_r <= in_data.target_freq;
      best_rdw_r <= '0;
      best_vdw_r <= '0;
      best_f_r   <= '0;
    end
    if (ctrl.take_limit) begin
      limit_r <= limit_nxt;
      rdw_r   <= '0;
    end
    if (ctrl.take_ab) begin
      a_r         <= div_quot;
      b_r         <= div_rem;
      vq_r        <= '0;
      vr_r        <= '0;
      vdw_r       <= '0;
      prime_cnt_r <= '0;
    end
    // step from a zero numerator up to 16*ref (vdw = 0)
    if (ctrl.prime) begin
      vq_r        <= vq_step;
      vr_r        <= vr_step;
      prime_cnt_r <= prime_cnt_r + 1'b1;
    end
    if (ctrl.mul) begin
      inr_r <= (vq_r >= VCO_MIN) && (vq_r <= VCO_MAX);
      f_r   <= prod[RECIP_SHIFT +: FREQ_W];
    end
    if (ctrl.cmp) begin
      if (better) begin
        best_err_r <= err;
        best_rdw_r <= RDW_W'(rdw_r);
        best_vdw_r <= vdw_r;
        best_f_r   <= f_r;
      end
      vq_r  <= vq_step;
      vr_r  <= vr_step;
      vdw_r <= vdw_r + 1'b1;
      if (stat.vdw_last) rdw_r <= rdw_r + 1'b1;
    end
  end

  // pack the result; a bad range code reports all zeros
  assign ok = !bad_r && (best_err_r <= ERR_MAX);
  always_comb begin
    res = '0;
    if (!bad_r) begin
      res.ok            = ok;
      res.best_rdw      = best_rdw_r;
      res.best_vdw      = best_vdw_r;
      res.achieved_freq = best_f_r;
      res.rdw_reg_byte  = {best_vdw_r[0], best_rdw_r};
      res.vdw_reg_byte  = {best_vdw_r[5], best_vdw_r[6], best_vdw_r[7],
                           best_vdw_r[8], best_vdw_r[4:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.finish) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
